// File: hdl/ght_pkg.sv
`default_nettype none

package ght_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned GEN_BITS  = 16;
  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_STALE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOVE
  } state_e;

  typedef enum logic [2:0] {
    RES_ALLOC_OK,
    RES_FULL,
    RES_STALE,
    RES_LOOKUP_OK,
    RES_FREE_OK
  } res_sel_e;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [GEN_BITS-1:0] gen_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // input item as packed on the stream, lowest field in the lowest bits
  typedef struct packed {
    gen_t       gen;
    slot_t      slot;
    logic [1:0] cmd;
  } in_item_t;

  typedef struct packed {
    cnt_t       live_count;
    slot_t      moved_from;
    logic       moved;
    slot_t      dense_index;
    gen_t       out_gen;
    slot_t      out_slot;
    logic [1:0] status;
  } result_t;

  localparam int unsigned IN_W         = $bits(in_item_t);
  localparam int unsigned RES_W        = $bits(result_t);
  localparam int unsigned IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic live;
    gen_t gen;
  } meta_t;

  typedef struct packed {
    gen_t  gen;
    slot_t slot;
  } fstk_t;

  // controller to datapath
  typedef struct packed {
    logic     accept;
    logic     owner_rd;
    logic     do_alloc;
    logic     do_free;
    logic     emit;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       alloc_full;
    logic       handle_ok;
    logic       out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// File: hdl/ght_ram.sv
`default_nettype none

module ght_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [$clog2(DEPTH)-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0]            wdata_i,
  input  wire logic                        re_i,
  input  wire logic [$clog2(DEPTH)-1:0]    raddr_i,
  output logic      [WIDTH-1:0]            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/ght_ctrl.sv
`default_nettype none

module ght_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire ght_pkg::ctrl_stat_t stat_i,
  output ght_pkg::ctrl_cmd_t       cmd_o
);
  import ght_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.res_sel = RES_STALE;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // slot tables and free stack top are readable now
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
          unique case (stat_i.cmd)
            CMD_ALLOC: begin
              cmd_o.emit = 1'b1;
              if (stat_i.alloc_full) begin
                cmd_o.res_sel = RES_FULL;
              end else begin
                cmd_o.do_alloc = 1'b1;
                cmd_o.res_sel  = RES_ALLOC_OK;
              end
            end
            CMD_FREE: begin
              if (stat_i.handle_ok) begin
                cmd_o.owner_rd = 1'b1;
                state_d        = ST_MOVE;
              end else begin
                cmd_o.emit = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              cmd_o.emit = 1'b1;
              if (stat_i.handle_ok) begin
                cmd_o.res_sel = RES_LOOKUP_OK;
              end
            end
            default: begin
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      ST_MOVE: begin
        if (stat_i.out_free) begin
          cmd_o.do_free = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = RES_FREE_OK;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ght_dp.sv
`default_nettype none

module ght_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ght_pkg::in_item_t  s_item_i,
  input  wire ght_pkg::ctrl_cmd_t cmd_i,
  output ght_pkg::ctrl_stat_t     stat_o,
  input  wire logic               m_ready_i,
  output logic                    m_valid_o,
  output ght_pkg::result_t        m_res_o
);
  import ght_pkg::*;

  logic [1:0] cmd_q;
  slot_t      hslot_q;
  gen_t       hgen_q;
  cnt_t       free_depth_q, free_depth_d;
  cnt_t       opened_q, opened_d;
  cnt_t       live_q, live_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q, res_d;

  // table ports
  logic  sd_we;
  slot_t sd_waddr, sd_wdata, sd_rdata;
  logic  meta_we;
  slot_t meta_waddr;
  meta_t meta_wdata, meta_rdata;
  logic  do_we;
  slot_t do_waddr, do_wdata, do_rdata;
  logic  fs_we;
  fstk_t fs_wdata, fs_rdata;

  cnt_t  live_m1, depth_m1;
  slot_t last;
  logic  fs_avail, alloc_full, handle_ok, out_free, mv;
  slot_t new_slot;
  gen_t  new_gen, gen_inc;

  assign live_m1  = live_q - cnt_t'(1);
  assign depth_m1 = free_depth_q - cnt_t'(1);
  assign last     = live_m1[SLOT_W-1:0];

  assign fs_avail   = free_depth_q != '0;
  assign alloc_full = !fs_avail && (opened_q == cnt_t'(MAX_SLOTS));
  assign new_slot   = fs_avail ? fs_rdata.slot : opened_q[SLOT_W-1:0];
  assign new_gen    = fs_avail ? fs_rdata.gen : '0;
  assign gen_inc    = meta_rdata.gen + gen_t'(1);
  assign handle_ok  = (cnt_t'(hslot_q) < opened_q) && meta_rdata.live &&
                      (meta_rdata.gen == hgen_q);
  assign out_free   = !out_valid_q || m_ready_i;
  // the hole is not the last entry, so the last one moves into it
  assign mv         = sd_rdata != last;

  assign stat_o.cmd        = cmd_q;
  assign stat_o.alloc_full = alloc_full;
  assign stat_o.handle_ok  = handle_ok;
  assign stat_o.out_free   = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= s_item_i.cmd;
      hslot_q <= s_item_i.slot;
      hgen_q  <= s_item_i.gen;
    end
    if (cmd_i.emit) begin
      out_res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_depth_q <= '0;
      opened_q     <= '0;
      live_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      free_depth_q <= free_depth_d;
      opened_q     <= opened_d;
      live_q       <= live_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    free_depth_d = free_depth_q;
    opened_d     = opened_q;
    live_d       = live_q;
    if (cmd_i.do_alloc) begin
      if (fs_avail) begin
        free_depth_d = depth_m1;
      end else begin
        opened_d = opened_q + cnt_t'(1);
      end
      live_d = live_q + cnt_t'(1);
    end else if (cmd_i.do_free) begin
      free_depth_d = free_depth_q + cnt_t'(1);
      live_d       = live_m1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.live_count = live_q;
    unique case (cmd_i.res_sel)
      RES_ALLOC_OK: begin
        res_d.status      = STATUS_OK;
        res_d.out_slot    = new_slot;
        res_d.out_gen     = new_gen;
        res_d.dense_index = live_q[SLOT_W-1:0];
        res_d.live_count  = live_q + cnt_t'(1);
      end
      RES_FULL: begin
        res_d.status = STATUS_FULL;
      end
      RES_STALE: begin
        res_d.status = STATUS_STALE;
      end
      RES_LOOKUP_OK: begin
        res_d.status      = STATUS_OK;
        res_d.dense_index = sd_rdata;
      end
      RES_FREE_OK: begin
        res_d.status      = STATUS_OK;
        res_d.dense_index = sd_rdata;
        res_d.moved       = mv;
        res_d.moved_from  = mv ? last : '0;
        res_d.live_count  = live_m1;
      end
      default: begin
        res_d.status = STATUS_STALE;
      end
    endcase
  end

  // write ports: allocate places the new entry, free patches the moved entry
  assign sd_we      = cmd_i.do_alloc || (cmd_i.do_free && mv);
  assign sd_waddr   = cmd_i.do_alloc ? new_slot : do_rdata;
  assign sd_wdata   = cmd_i.do_alloc ? live_q[SLOT_W-1:0] : sd_rdata;

  assign meta_we    = cmd_i.do_alloc || cmd_i.do_free;
  assign meta_waddr = cmd_i.do_alloc ? new_slot : hslot_q;
  assign meta_wdata = cmd_i.do_alloc ? meta_t'{live: 1'b1, gen: new_gen}
                                     : meta_t'{live: 1'b0, gen: gen_inc};

  assign do_we      = cmd_i.do_alloc || (cmd_i.do_free && mv);
  assign do_waddr   = cmd_i.do_alloc ? live_q[SLOT_W-1:0] : sd_rdata;
  assign do_wdata   = cmd_i.do_alloc ? new_slot : do_rdata;

  // freed slots carry their next generation on the stack
  assign fs_we      = cmd_i.do_free;
  assign fs_wdata   = fstk_t'{gen: gen_inc, slot: hslot_q};

  ght_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_slot_dense (
    .clk_i   (clk_i),
    .we_i    (sd_we),
    .waddr_i (sd_waddr),
    .wdata_i (sd_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (s_item_i.slot),
    .rdata_o (sd_rdata)
  );

  ght_ram #(.WIDTH($bits(meta_t)), .DEPTH(MAX_SLOTS)) u_slot_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (s_item_i.slot),
    .rdata_o (meta_rdata)
  );

  ght_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_dense_owner (
    .clk_i   (clk_i),
    .we_i    (do_we),
    .waddr_i (do_waddr),
    .wdata_i (do_wdata),
    .re_i    (cmd_i.owner_rd),
    .raddr_i (last),
    .rdata_o (do_rdata)
  );

  ght_ram #(.WIDTH($bits(fstk_t)), .DEPTH(MAX_SLOTS)) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (free_depth_q[SLOT_W-1:0]),
    .wdata_i (fs_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (depth_m1[SLOT_W-1:0]),
    .rdata_o (fs_rdata)
  );

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_res_q;

`ifndef SYNTH
  // every opened slot is either live or waiting on the free stack
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, live_q} + {1'b0, free_depth_q}) == {1'b0, opened_q})
    else $error("live and free counts do not add up to opened slots");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded while output register still full");

  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_free |-> (cnt_t'(sd_rdata) < live_q))
    else $error("freed entry lies outside the dense range");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_alloc |-> (!alloc_full && (live_q < cnt_t'(MAX_SLOTS))))
    else $error("allocate on a full table");

  a_live_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_free |=> (live_q == ($past(live_q) - cnt_t'(1))))
    else $error("free did not drop the live count by one");
`endif

endmodule

`default_nettype wire

// File: hdl/generational_handle_table_top.sv
`default_nettype none

// Generational handle table with a packed dense array. Commands arrive as
// items on the slave stream: allocate, free and look up. Allocate reuses the
// most recently freed slot (carrying its bumped generation) or opens a new
// slot at generation zero, and places the entry at the end of the dense
// array. Free checks the handle, swap-removes its dense entry and reports
// the move (moved, moved_from -> dense_index) so outside arrays can follow.
// Stale handles give status 1 and leave the table alone; allocate with all
// slots in use gives status 2. Each item yields exactly one result item.
// Allocate, look up and any failing command pass from accept through the
// check state to the result; a successful free adds a move state for the
// registered read of the dense owner table, which starts only once the
// handle check has passed. A new item is accepted the cycle after the
// previous result is loaded, so a result may wait in the output register
// while the next item is worked on. The tables need no clearing after
// reset.
module generational_handle_table_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // cmd[1:0], handle_slot[11:2], handle_gen[27:12], zero fill above
  input  wire logic [ght_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status[1:0], out_slot[11:2], out_gen[27:12], dense_index[37:28],
  // moved[38], moved_from[48:39], live_count[59:49], zero fill above
  output logic [ght_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import ght_pkg::*;

  in_item_t   s_item;
  result_t    m_res;
  ctrl_cmd_t  ctrl_cmd;
  ctrl_stat_t ctrl_stat;

  assign s_item = in_item_t'(s_axis_tdata[IN_W-1:0]);

  ght_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (ctrl_stat),
    .cmd_o     (ctrl_cmd)
  );

  ght_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_item_i  (s_item),
    .cmd_i     (ctrl_cmd),
    .stat_o    (ctrl_stat),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, m_res};

endmodule

`default_nettype wire
